// ===== rtl/core/dgtd_pkg.sv =====
// ----------------------------------------------------------------------------
// dgtd_pkg
// Shared types, constants and table lookups for the DShot GCR telemetry decoder.
// ----------------------------------------------------------------------------
package dgtd_pkg;

    localparam logic [4:0]  FRAME_LEN  = 5'd21;
    localparam logic [4:0]  BITS_SAT   = 5'd22;
    localparam int          ERPM_W     = 20;
    localparam int          PERIOD_W   = 16;
    localparam logic [ERPM_W-1:0] ERPM_SCALE = 20'd600000;
    localparam logic [11:0] STOP_CODE  = 12'hFFF;
    localparam logic [3:0]  CSUM_OK    = 4'hF;
    localparam logic [4:0]  DIV_LAST   = 5'd19;

    localparam logic [3:0] GCR_TABLE [32] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
        4'd0, 4'd9, 4'd10, 4'd11, 4'd0, 4'd13, 4'd14, 4'd15,
        4'd0, 4'd0, 4'd2, 4'd3, 4'd0, 4'd5, 4'd6, 4'd7,
        4'd0, 4'd0, 4'd8, 4'd1, 4'd0, 4'd4, 4'd12, 4'd0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_TAIL,
        ST_CHECK,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic load_edge;
        logic add_tail;
        logic clear;
    } frm_cmd_t;

    typedef struct packed {
        logic [20:0] frame;
        logic [4:0]  bits;
        logic        run_err;
    } frm_stat_t;

    // 5b/4b decode of the low 20 frame bits, lowest group into lowest nibble
    function automatic logic [15:0] gcr_decode(input logic [19:0] code);
        logic [15:0] word;
        word = '0;
        for (int g = 0; g < 4; g++) begin
            word[4*g +: 4] = GCR_TABLE[code[5*g +: 5]];
        end
        return word;
    endfunction

    function automatic logic [3:0] nibble_csum(input logic [15:0] word);
        return word[15:12] ^ word[11:8] ^ word[7:4] ^ word[3:0];
    endfunction

endpackage

// ===== rtl/core/dgtd_frame.sv =====
// ----------------------------------------------------------------------------
// dgtd_frame
// Edge gap to bit-run conversion and 21-bit frame assembly.
// ----------------------------------------------------------------------------
module dgtd_frame #(
    parameter int STAMP_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [STAMP_BITS-1:0]   edge_time,
    input  dgtd_pkg::frm_cmd_t      cmd,
    output dgtd_pkg::frm_stat_t     stat
);
    import dgtd_pkg::*;

    localparam int LEN_W = STAMP_BITS - 3;

    logic [STAMP_BITS-1:0] prev_reg, prev_next;
    logic                  seen_reg, seen_next;
    logic [4:0]            bits_reg, bits_next;
    logic [20:0]           frame_reg, frame_next;
    logic                  err_reg, err_next;

    logic [STAMP_BITS-1:0] gap;
    logic [STAMP_BITS:0]   gap_round;
    logic [LEN_W-1:0]      gap_len;
    logic [LEN_W-1:0]      run_len;
    logic [4:0]            sh;
    logic [5:0]            bits_sum;
    logic                  run_en;

    assign gap       = edge_time - prev_reg;
    assign gap_round = {1'b0, gap} + (STAMP_BITS+1)'(8);
    assign gap_len   = gap_round[STAMP_BITS:4];
    assign run_len   = cmd.add_tail ? LEN_W'(FRAME_LEN - bits_reg) : gap_len;
    assign sh        = run_len[4:0];
    assign bits_sum  = {1'b0, bits_reg} + {1'b0, sh};

    assign run_en = (cmd.load_edge && seen_reg && (bits_reg < FRAME_LEN)) ||
                    (cmd.add_tail && (bits_reg < FRAME_LEN) && !err_reg);

    always_comb begin
        prev_next  = prev_reg;
        seen_next  = seen_reg;
        bits_next  = bits_reg;
        frame_next = frame_reg;
        err_next   = err_reg;
        if (cmd.clear) begin
            prev_next  = '0;
            seen_next  = 1'b0;
            bits_next  = '0;
            frame_next = '0;
            err_next   = 1'b0;
        end else begin
            if (cmd.load_edge) begin
                prev_next = edge_time;
                seen_next = 1'b1;
            end
            if (run_en) begin
                if (run_len == '0) begin
                    err_next = 1'b1;
                end else begin
                    // saturate the count, drop the frame on an overlong run
                    if (run_len > LEN_W'(BITS_SAT) || bits_sum > 6'(BITS_SAT)) begin
                        bits_next = BITS_SAT;
                    end else begin
                        bits_next = bits_sum[4:0];
                    end
                    if (run_len > LEN_W'(FRAME_LEN)) begin
                        frame_next = '0;
                    end else begin
                        frame_next = (frame_reg << sh) | (21'd1 << (sh - 5'd1));
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            seen_reg  <= 1'b0;
            bits_reg  <= '0;
            frame_reg <= '0;
            err_reg   <= 1'b0;
        end else begin
            prev_reg  <= prev_next;
            seen_reg  <= seen_next;
            bits_reg  <= bits_next;
            frame_reg <= frame_next;
            err_reg   <= err_next;
        end
    end

    assign stat.frame   = frame_reg;
    assign stat.bits    = bits_reg;
    assign stat.run_err = err_reg;

endmodule

// ===== rtl/core/dgtd_divider.sv =====
// ----------------------------------------------------------------------------
// dgtd_divider
// Restoring divider, one quotient bit per cycle on a shared subtractor.
// ----------------------------------------------------------------------------
module dgtd_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [dgtd_pkg::ERPM_W-1:0]   dividend,
    input  logic [dgtd_pkg::PERIOD_W-1:0] divisor,
    output logic                          busy,
    output logic                          done,
    output logic [dgtd_pkg::ERPM_W-1:0]   quotient
);
    import dgtd_pkg::*;

    logic [PERIOD_W-1:0] rem_reg, rem_next;
    logic [ERPM_W-1:0]   quo_reg, quo_next;
    logic [PERIOD_W-1:0] den_reg, den_next;
    logic [4:0]          cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                take;

    assign trial = {rem_reg, quo_reg[ERPM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = (trial >= {1'b0, den_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops out
            rem_next = take ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            quo_next = {quo_reg[ERPM_W-2:0], take};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == DIV_LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/dshot_gcr_telemetry_decoder_top.sv =====
// ----------------------------------------------------------------------------
// dshot_gcr_telemetry_decoder_top
// Bidirectional DShot eRPM telemetry decoder from edge timestamps.
//
//   Channel  Dir  Word contents (lowest bit up)        Word meaning
//   s_*      in   tdata: edge_time[31:0]; tlast        one captured line edge
//   m_*      out  tdata: erpm_value[19:0], 0-pad;      one result per frame
//                 tuser: packet_valid
//
// A non-last edge passes accept and run update. The last edge passes through
// accept, run update, tail pad, GCR check, divide (20 quotient bits, then the
// done flag) and delivery; a rejected or stop-code frame skips the divide.
// Reset is synchronous, active low, and clears the frame and all control.
// A result waiting on m_tready holds the sequencer at delivery; the input
// side is ready only while the sequencer is idle.
// ----------------------------------------------------------------------------
module dshot_gcr_telemetry_decoder_top #(
    parameter int STAMP_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] edge_time
    input  logic        s_tlast,     // last_edge
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [19:0] erpm_value, [23:20] zero
    output logic        m_tuser      // [0] packet_valid
);
    import dgtd_pkg::*;

    state_t state_reg, state_next;

    // captured edge word
    logic [STAMP_BITS-1:0] edge_reg, edge_next;
    logic                  last_reg, last_next;

    // result waiting for the output register
    logic [ERPM_W-1:0]     res_erpm_reg, res_erpm_next;
    logic                  res_ok_reg, res_ok_next;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [ERPM_W-1:0]     out_erpm_reg, out_erpm_next;
    logic                  out_ok_reg, out_ok_next;

    frm_cmd_t              frm_cmd;
    frm_stat_t             frm_stat;

    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [ERPM_W-1:0]     div_quot;
    logic [ERPM_W-1:0]     div_dividend;

    logic                  s_accept;
    logic                  out_free;
    logic [15:0]           gcr_word;
    logic [11:0]           payload;
    logic [PERIOD_W-1:0]   period;
    logic                  frame_bad;

    // ready is high exactly in idle
    assign s_accept = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    // decode path, used in the check state
    assign gcr_word     = gcr_decode(frm_stat.frame[19:0]);
    assign payload      = gcr_word[15:4];
    assign period       = PERIOD_W'({7'd0, payload[8:0]} << payload[11:9]);
    assign frame_bad    = frm_stat.run_err || (frm_stat.bits != FRAME_LEN) ||
                          (nibble_csum(gcr_word) != CSUM_OK);
    assign div_dividend = ERPM_SCALE + ERPM_W'(period >> 1);

    dgtd_frame #(
        .STAMP_BITS (STAMP_BITS)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .edge_time (edge_reg),
        .cmd       (frm_cmd),
        .stat      (frm_stat)
    );

    dgtd_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (period),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        edge_reg     <= edge_next;
        last_reg     <= last_next;
        res_erpm_reg <= res_erpm_next;
        res_ok_reg   <= res_ok_next;
        out_erpm_reg <= out_erpm_next;
        out_ok_reg   <= out_ok_next;
    end

    always_comb begin
        state_next    = state_reg;
        edge_next     = edge_reg;
        last_next     = last_reg;
        res_erpm_next = res_erpm_reg;
        res_ok_next   = res_ok_reg;
        out_erpm_next = out_erpm_reg;
        out_ok_next   = out_ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        frm_cmd       = '0;
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    edge_next  = s_tdata[STAMP_BITS-1:0];
                    last_next  = s_tlast;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // close the run ending at this edge
                frm_cmd.load_edge = 1'b1;
                state_next = last_reg ? ST_TAIL : ST_IDLE;
            end
            ST_TAIL: begin
                frm_cmd.add_tail = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                // frame is consumed here; clear it for the next one
                frm_cmd.clear = 1'b1;
                priority if (frame_bad || (payload != STOP_CODE && period == '0)) begin
                    res_erpm_next = '0;
                    res_ok_next   = 1'b0;
                    state_next    = ST_DELIVER;
                end else if (payload == STOP_CODE) begin
                    res_erpm_next = '0;
                    res_ok_next   = 1'b1;
                    state_next    = ST_DELIVER;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    res_erpm_next = div_quot;
                    res_ok_next   = 1'b1;
                    state_next    = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                // hold until the output register is free
                if (out_free) begin
                    out_erpm_next = res_erpm_reg;
                    out_ok_next   = res_ok_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_erpm_reg};
    assign m_tuser  = out_ok_reg;

    a_ready_not_dividing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_busy)
        else $error("input ready while divider busy");

    a_start_enters_divide: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> (state_reg == ST_DIVIDE))
        else $error("divider started outside check");

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invalid packet with non-zero value");

    a_bits_saturate: assert property (@(posedge aclk) disable iff (!aresetn)
        frm_stat.bits <= BITS_SAT)
        else $error("bit count beyond saturation");

    a_erpm_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:0] <= ERPM_SCALE))
        else $error("erpm value out of range");

endmodule
